/* rtl/rbsfh_pkg.sv */
// Shared types, opcodes and saturation helpers for the ray / box first-hit unit.
// No dependencies.
package rbsfh_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned BoxW   = 6 * CoordW + 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_CAST  = 2'd2;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [CoordW-1:0] coord_t;

  // one slot's result leaving the slab pipeline
  typedef struct packed {
    logic v;
    logic hit;
    logic last;
  } slab_res_t;

  function automatic coord_t sat33(input logic signed [32:0] v);
    coord_t r;
    if (v > 33'sh0_7FFF_FFFF) r = Q_MAX;
    else if (v < -33'sh0_8000_0000) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic coord_t sat48(input logic signed [47:0] v);
    coord_t r;
    if (v > 48'sh0000_7FFF_FFFF) r = Q_MAX;
    else if (v < -48'sh0000_8000_0000) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // floor(p / 2^16) of a 64-bit product, saturated
  function automatic coord_t qshift(input logic signed [63:0] p);
    return sat48(p[63:16]);
  endfunction

endpackage

/* rtl/ray_box_slab_first_hit_unit.sv */
// Ray / axis-aligned box first-hit unit: top level, FSM, box table and point math.
// Depends on rbsfh_pkg, rbsfh_ram, rbsfh_recip, rbsfh_slab.

// After reset the unit clears its box table, one slot a cycle, with busy high. A write
// or clear word is taken while idle and gives no result. A cast word first runs the
// serial reciprocals, then scans the table one slot a cycle through a six-stage slab
// pipeline until the first valid box that overlaps, then forms the intersection point
// in the S_PROD and S_SUM states. The result word is shown for one cycle on
// result_valid_o and cannot be held off; busy drops in that same cycle.
module ray_box_slab_first_hit_unit #(
  parameter int unsigned NUM_BOXES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        opcode_i,
  input  logic [rbsfh_pkg::SlotW-1:0]       slot_i,
  input  logic signed [31:0]                coord_a_x_i,
  input  logic signed [31:0]                coord_a_y_i,
  input  logic signed [31:0]                coord_a_z_i,
  input  logic signed [31:0]                coord_b_x_i,
  input  logic signed [31:0]                coord_b_y_i,
  input  logic signed [31:0]                coord_b_z_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [rbsfh_pkg::SlotW-1:0]       hit_slot_o,
  output logic signed [31:0]                point_x_o,
  output logic signed [31:0]                point_y_o,
  output logic signed [31:0]                point_z_o
);

  localparam int unsigned AddrW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int unsigned BoxW  = rbsfh_pkg::BoxW;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RECIP = 6'b000100,
    S_SCAN  = 6'b001000,
    S_PROD  = 6'b010000,
    S_SUM   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             issuing_q, issuing_d;
  logic             accept, in_range, idx_last, issue;

  rbsfh_pkg::coord_t org_q [3];
  rbsfh_pkg::coord_t dir_q [3];
  rbsfh_pkg::coord_t inv [3];
  logic [2:0]        recip_done;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [BoxW-1:0]  ram_wdata, ram_rdata;

  rbsfh_pkg::slab_res_t sres;
  logic [AddrW-1:0]     sidx;
  rbsfh_pkg::coord_t    stmin;

  rbsfh_pkg::coord_t   tmin_q;
  logic [AddrW-1:0]    hidx_q;
  logic signed [63:0]  prod_q [3];
  rbsfh_pkg::coord_t   pq [3];

  logic                      rv_q, rv_d;
  logic                      hit_q;
  logic [rbsfh_pkg::SlotW-1:0] hslot_q;
  rbsfh_pkg::coord_t         pt_q [3];

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = 32'(slot_i) < 32'(NUM_BOXES);
  assign idx_last = (idx_q == AddrW'(NUM_BOXES - 1));
  assign issue    = (state_q == S_SCAN) && issuing_q;

  // table port: clear sweep, write/clear words, scan reads
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = '0;
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_q == S_IDLE) begin
      ram_addr = AddrW'(slot_i);
      if (accept && in_range && opcode_i == rbsfh_pkg::OP_WRITE) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, coord_b_z_i, coord_b_y_i, coord_b_x_i,
                     coord_a_z_i, coord_a_y_i, coord_a_x_i};
      end else if (accept && in_range && opcode_i == rbsfh_pkg::OP_CLEAR) begin
        ram_we = 1'b1;
      end
    end
  end

  rbsfh_ram #(.Width(BoxW), .Depth(NUM_BOXES), .AddrW(AddrW)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic cast_go;
  assign cast_go = accept && (opcode_i == rbsfh_pkg::OP_CAST);

  rbsfh_recip u_recip_x (.clk_i, .rst_ni, .start_i(cast_go), .d_i(coord_b_x_i),
                         .done_o(recip_done[0]), .recip_o(inv[0]));
  rbsfh_recip u_recip_y (.clk_i, .rst_ni, .start_i(cast_go), .d_i(coord_b_y_i),
                         .done_o(recip_done[1]), .recip_o(inv[1]));
  rbsfh_recip u_recip_z (.clk_i, .rst_ni, .start_i(cast_go), .d_i(coord_b_z_i),
                         .done_o(recip_done[2]), .recip_o(inv[2]));

  rbsfh_slab #(.AddrW(AddrW)) u_slab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (state_q == S_SCAN),
    .issue_i (issue),
    .last_i  (idx_last),
    .idx_i   (idx_q),
    .box_i   (ram_rdata),
    .org_i   (org_q),
    .inv_i   (inv),
    .res_o   (sres),
    .idx_o   (sidx),
    .tmin_o  (stmin)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    issuing_d = issuing_q;
    rv_d      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        idx_d = idx_q + AddrW'(1);
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cast_go) state_d = S_RECIP;
      end
      S_RECIP: begin
        if (&recip_done) begin
          state_d   = S_SCAN;
          idx_d     = '0;
          issuing_d = 1'b1;
        end
      end
      S_SCAN: begin
        if (issuing_q) begin
          idx_d = idx_q + AddrW'(1);
          if (idx_last) issuing_d = 1'b0;
        end
        if (sres.v && sres.hit) begin
          state_d   = S_PROD;
          issuing_d = 1'b0;
        end else if (sres.last) begin
          state_d = S_IDLE;
          rv_d    = 1'b1;
        end
      end
      S_PROD:  state_d = S_SUM;
      S_SUM: begin
        state_d = S_IDLE;
        rv_d    = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      issuing_q <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      issuing_q <= issuing_d;
      rv_q      <= rv_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) pq[k] = rbsfh_pkg::qshift(prod_q[k]);
  end

  // payload: ray, winning slot, point
  always_ff @(posedge clk_i) begin
    if (cast_go) begin
      org_q[0] <= coord_a_x_i;
      org_q[1] <= coord_a_y_i;
      org_q[2] <= coord_a_z_i;
      dir_q[0] <= coord_b_x_i;
      dir_q[1] <= coord_b_y_i;
      dir_q[2] <= coord_b_z_i;
    end
    if (state_q == S_SCAN && sres.v && sres.hit) begin
      tmin_q <= stmin;
      hidx_q <= sidx;
    end
    for (int k = 0; k < 3; k++) prod_q[k] <= dir_q[k] * tmin_q;
    if (state_q == S_SCAN) begin
      hit_q   <= 1'b0;
      hslot_q <= '0;
      for (int k = 0; k < 3; k++) pt_q[k] <= '0;
    end
    if (state_q == S_SUM) begin
      hit_q   <= 1'b1;
      hslot_q <= rbsfh_pkg::SlotW'(hidx_q);
      for (int k = 0; k < 3; k++) begin
        pt_q[k] <= rbsfh_pkg::sat33(33'(signed'({org_q[k][31], org_q[k]}))
                 + 33'(signed'({pq[k][31], pq[k]})));
      end
    end
  end

  assign result_valid_o = rv_q;
  assign hit_o          = hit_q;
  assign hit_slot_o     = hslot_q;
  assign point_x_o      = pt_q[0];
  assign point_y_o      = pt_q[1];
  assign point_z_o      = pt_q[2];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result word without a query in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !hit_o |-> hit_slot_o == '0 && point_x_o == '0 &&
                                 point_y_o == '0 && point_z_o == '0)
    else $error("miss word carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i == rbsfh_pkg::OP_CAST |=> busy)
    else $error("cast word did not start a query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_CLEAR || state_q == S_IDLE)
    else $error("table written during a query");

endmodule

/* rtl/rbsfh_ram.sv */
// Generic single-port RAM, registered read.
// No dependencies.
module rbsfh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end

endmodule

/* rtl/rbsfh_recip.sv */
// Bit-serial reciprocal 2^32 / d of a Q16.16 value, saturated, one quotient bit a cycle.
// Depends on rbsfh_pkg.
module rbsfh_recip (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  rbsfh_pkg::coord_t     d_i,
  output logic                  done_o,
  output rbsfh_pkg::coord_t     recip_o
);

  localparam int unsigned Steps = 33;

  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        neg_q, neg_d;
  logic [32:0] mag_q, mag_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic        done_q, done_d;
  logic [33:0] shifted;

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    // dividend is 2^32: only its top bit is set
    shifted = {rem_q[32:0], (cnt_q == 6'd0)};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = '0;
      neg_d = d_i[31];
      mag_d = d_i[31] ? 33'(-{d_i[31], d_i}) : {1'b0, d_i};
    end else if (run_q) begin
      if (shifted >= {1'b0, mag_q}) begin
        rem_d = shifted - {1'b0, mag_q};
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(Steps - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // zero divisor leaves an all-ones quotient, which saturates to the positive max
  always_comb begin
    if (!neg_q) recip_o = (quo_q > 33'h0_7FFF_FFFF) ? rbsfh_pkg::Q_MAX : quo_q[31:0];
    else recip_o = (quo_q >= 33'h0_8000_0000) ? rbsfh_pkg::Q_MIN : -quo_q[31:0];
  end

  assign done_o = done_q;

endmodule

/* rtl/rbsfh_slab.sv */
// Pipelined X/Y/Z slab test, one table word per cycle, fed by the box RAM read port.
// Depends on rbsfh_pkg.
module rbsfh_slab #(
  parameter int unsigned AddrW = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         issue_i,
  input  logic                         last_i,
  input  logic [AddrW-1:0]             idx_i,
  input  logic [rbsfh_pkg::BoxW-1:0]   box_i,
  input  rbsfh_pkg::coord_t            org_i [3],
  input  rbsfh_pkg::coord_t            inv_i [3],
  output rbsfh_pkg::slab_res_t         res_o,
  output logic [AddrW-1:0]             idx_o,
  output rbsfh_pkg::coord_t            tmin_o
);

  localparam int unsigned Stages = 6;

  logic [Stages-1:0] v_q, last_q;
  logic [AddrW-1:0]  idx_q [Stages];

  rbsfh_pkg::coord_t lo [3];
  rbsfh_pkg::coord_t hi [3];
  rbsfh_pkg::coord_t dlo_q [3];
  rbsfh_pkg::coord_t dhi_q [3];
  logic signed [63:0] plo_q [3];
  logic signed [63:0] phi_q [3];
  rbsfh_pkg::coord_t near_q [3];
  rbsfh_pkg::coord_t far_q [3];
  logic              rej_q, hit_q;
  rbsfh_pkg::coord_t tmin_q, tmax_q, nz_q, fz_q, tfin_q;
  rbsfh_pkg::coord_t tmin_c, tmax_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = box_i[k*32 +: 32];
      hi[k] = box_i[(k+3)*32 +: 32];
    end
    tmin_c = (near_q[1] > near_q[0]) ? near_q[1] : near_q[0];
    tmax_c = (far_q[1] < far_q[0]) ? far_q[1] : far_q[0];
  end

  // valid chain; stage 1 also drops slots whose valid bit is clear
  // last marker rides with the last issued slot, valid or not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      last_q <= '0;
    end else begin
      v_q[0] <= issue_i & en_i;
      v_q[1] <= v_q[0] & box_i[rbsfh_pkg::BoxW-1] & en_i;
      for (int s = 2; s < Stages; s++) v_q[s] <= v_q[s-1] & en_i;
      last_q[0] <= issue_i & last_i & en_i;
      for (int s = 1; s < Stages; s++) last_q[s] <= last_q[s-1] & en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q[0]  <= idx_i;
    for (int s = 1; s < Stages; s++) begin
      idx_q[s]  <= idx_q[s-1];
    end
    // v_q[0] -> v_q[1]: saturated bound minus origin
    for (int k = 0; k < 3; k++) begin
      dlo_q[k] <= rbsfh_pkg::sat33(33'(signed'({lo[k][31], lo[k]}))
                                   - 33'(signed'({org_i[k][31], org_i[k]})));
      dhi_q[k] <= rbsfh_pkg::sat33(33'(signed'({hi[k][31], hi[k]}))
                                   - 33'(signed'({org_i[k][31], org_i[k]})));
    end
    // -> v_q[2]: products
    for (int k = 0; k < 3; k++) begin
      plo_q[k] <= dlo_q[k] * inv_i[k];
      phi_q[k] <= dhi_q[k] * inv_i[k];
    end
    // -> v_q[3]: scale, order near/far by sign of reciprocal
    for (int k = 0; k < 3; k++) begin
      if (!inv_i[k][31]) begin
        near_q[k] <= rbsfh_pkg::qshift(plo_q[k]);
        far_q[k]  <= rbsfh_pkg::qshift(phi_q[k]);
      end else begin
        near_q[k] <= rbsfh_pkg::qshift(phi_q[k]);
        far_q[k]  <= rbsfh_pkg::qshift(plo_q[k]);
      end
    end
    // -> v_q[4]: X/Y overlap
    rej_q  <= (near_q[0] > far_q[1]) || (near_q[1] > far_q[0]);
    tmin_q <= tmin_c;
    tmax_q <= tmax_c;
    nz_q   <= near_q[2];
    fz_q   <= far_q[2];
    // -> v_q[5]: Z overlap
    hit_q  <= !rej_q && !(tmin_q > fz_q) && !(nz_q > tmax_q);
    tfin_q <= (nz_q > tmin_q) ? nz_q : tmin_q;
  end

  assign res_o.v    = v_q[Stages-1];
  assign res_o.hit  = hit_q;
  assign res_o.last = last_q[Stages-1];
  assign idx_o      = idx_q[Stages-1];
  assign tmin_o     = tfin_q;

  // a slot only reaches the end with a valid bit upstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-1] |-> $past(v_q[Stages-2]))
    else $error("slab pipeline valid out of step");

endmodule

/* dv/tb_ray_box_slab_first_hit_unit.sv */
// Self-checking bench for ray_box_slab_first_hit_unit: box table writes, clears and ray casts.
// A scoreboard class mirrors the table and predicts each cast word; depends on rbsfh_pkg.
module tb_ray_box_slab_first_hit_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned NBOX = 1024;
  localparam int unsigned SW = rbsfh_pkg::SlotW;
  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;

  typedef struct {
    logic              hit;
    logic [SW-1:0]     slot;
    rbsfh_pkg::coord_t px;
    rbsfh_pkg::coord_t py;
    rbsfh_pkg::coord_t pz;
  } cast_word_t;

  class hit_scoreboard;
    bit     valid[NBOX];
    longint lo_x[NBOX], lo_y[NBOX], lo_z[NBOX];
    longint hi_x[NBOX], hi_y[NBOX], hi_z[NBOX];
    cast_word_t pending_q[$];
    int errors;

    function longint clamp32(longint v);
      if (v > QHI) return QHI;
      if (v < QLO) return QLO;
      return v;
    endfunction

    // floor(a*b / 2^16), saturated
    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp32(p >>> 16);
    endfunction

    function longint recip(longint d);
      longint mag, q;
      if (d == 0) return QHI;
      mag = (d < 0) ? -d : d;
      q = 64'sh1_0000_0000 / mag;
      if (d > 0) return (q > QHI) ? QHI : q;
      return (q >= 64'sh8000_0000) ? QLO : -q;
    endfunction

    function void slab_span(longint lo, longint hi, longint org, longint inv,
                            output longint tn, output longint tf);
      longint a, b;
      a = qmul(clamp32(lo - org), inv);
      b = qmul(clamp32(hi - org), inv);
      if (inv >= 0) begin tn = a; tf = b; end
      else begin tn = b; tf = a; end
    endfunction

    function void note_word(logic [1:0] op, logic [SW-1:0] s,
                            rbsfh_pkg::coord_t ax, rbsfh_pkg::coord_t ay,
                            rbsfh_pkg::coord_t az, rbsfh_pkg::coord_t bx,
                            rbsfh_pkg::coord_t by, rbsfh_pkg::coord_t bz);
      cast_word_t w;
      longint ix, iy, iz, nx, fx, ny, fy, nz, fz, tmin, tmax;
      if (op == rbsfh_pkg::OP_WRITE) begin
        lo_x[s] = ax; lo_y[s] = ay; lo_z[s] = az;
        hi_x[s] = bx; hi_y[s] = by; hi_z[s] = bz;
        valid[s] = 1'b1;
        return;
      end
      if (op == rbsfh_pkg::OP_CLEAR) begin
        valid[s] = 1'b0;
        return;
      end
      if (op != rbsfh_pkg::OP_CAST) return;
      ix = recip(bx); iy = recip(by); iz = recip(bz);
      w = '{1'b0, '0, '0, '0, '0};
      for (int i = 0; i < NBOX; i++) begin
        if (!valid[i]) continue;
        slab_span(lo_x[i], hi_x[i], ax, ix, nx, fx);
        slab_span(lo_y[i], hi_y[i], ay, iy, ny, fy);
        if (nx > fy || ny > fx) continue;
        tmin = (ny > nx) ? ny : nx;
        tmax = (fy < fx) ? fy : fx;
        slab_span(lo_z[i], hi_z[i], az, iz, nz, fz);
        if (tmin > fz || nz > tmax) continue;
        if (nz > tmin) tmin = nz;
        w.hit  = 1'b1;
        w.slot = SW'(i);
        w.px = rbsfh_pkg::coord_t'(clamp32(longint'(ax) + qmul(bx, tmin)));
        w.py = rbsfh_pkg::coord_t'(clamp32(longint'(ay) + qmul(by, tmin)));
        w.pz = rbsfh_pkg::coord_t'(clamp32(longint'(az) + qmul(bz, tmin)));
        break;
      end
      pending_q = {pending_q, w};
    endfunction

    function void check_result(logic h, logic [SW-1:0] s,
                               rbsfh_pkg::coord_t px, rbsfh_pkg::coord_t py,
                               rbsfh_pkg::coord_t pz);
      cast_word_t w;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word hit=%0d slot=%0d", $time, h, s);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (h !== w.hit) begin
        $display("%0t: hit exp %0d got %0d", $time, w.hit, h); errors++;
      end
      if (s !== w.slot) begin
        $display("%0t: hit_slot exp %0d got %0d", $time, w.slot, s); errors++;
      end
      if (px !== w.px) begin
        $display("%0t: point_x exp %h got %h", $time, w.px, px); errors++;
      end
      if (py !== w.py) begin
        $display("%0t: point_y exp %h got %h", $time, w.py, py); errors++;
      end
      if (pz !== w.pz) begin
        $display("%0t: point_z exp %h got %h", $time, w.pz, pz); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode_i = '0;
  logic [SW-1:0] slot_i = '0;
  rbsfh_pkg::coord_t coord_a_x_i = '0, coord_a_y_i = '0, coord_a_z_i = '0;
  rbsfh_pkg::coord_t coord_b_x_i = '0, coord_b_y_i = '0, coord_b_z_i = '0;
  logic result_valid_o, hit_o;
  logic [SW-1:0] hit_slot_o;
  rbsfh_pkg::coord_t point_x_o, point_y_o, point_z_o;

  hit_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  ray_box_slab_first_hit_unit dut (.*);

  // outputs only move on the rising edge, so the falling edge is a safe sample point
  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(hit_o, hit_slot_o, point_x_o, point_y_o, point_z_o);
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_word(logic [1:0] op, logic [SW-1:0] s,
                           rbsfh_pkg::coord_t ax, rbsfh_pkg::coord_t ay,
                           rbsfh_pkg::coord_t az, rbsfh_pkg::coord_t bx,
                           rbsfh_pkg::coord_t by, rbsfh_pkg::coord_t bz);
    start <= 1'b1;
    opcode_i <= op; slot_i <= s;
    coord_a_x_i <= ax; coord_a_y_i <= ay; coord_a_z_i <= az;
    coord_b_x_i <= bx; coord_b_y_i <= by; coord_b_z_i <= bz;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    sb.note_word(op, s, ax, ay, az, bx, by, bz);
    idle_gap();
  endtask

  function automatic rbsfh_pkg::coord_t pick_coord(bit wide);
    if (wide) return rbsfh_pkg::coord_t'($urandom);
    return rbsfh_pkg::coord_t'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
  endfunction

  function automatic rbsfh_pkg::coord_t pick_dir(bit wide);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return rbsfh_pkg::coord_t'($urandom);
      default: return wide ? rbsfh_pkg::coord_t'($urandom)
                           : rbsfh_pkg::coord_t'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rbsfh_pkg::coord_t lo, sz;
    int kind;
    bit wide;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty table, zero direction
    send_word(rbsfh_pkg::OP_CAST, 0, 0, 0, 0, 0, 0, 0);
    send_word(rbsfh_pkg::OP_WRITE, 0, -(1 << 16), -(1 << 16), -(1 << 16),
              1 << 16, 1 << 16, 1 << 16);
    send_word(rbsfh_pkg::OP_WRITE, 1023, rbsfh_pkg::Q_MIN, rbsfh_pkg::Q_MIN,
              rbsfh_pkg::Q_MIN, rbsfh_pkg::Q_MAX, rbsfh_pkg::Q_MAX, rbsfh_pkg::Q_MAX);
    send_word(rbsfh_pkg::OP_CAST, 0, 5 << 16, 0, 0, -1, 1, 32'sh0001_0000);
    send_word(rbsfh_pkg::OP_CAST, 0, rbsfh_pkg::Q_MAX, rbsfh_pkg::Q_MIN,
              rbsfh_pkg::Q_MAX, rbsfh_pkg::Q_MIN, rbsfh_pkg::Q_MAX, rbsfh_pkg::Q_MIN);
    send_word(rbsfh_pkg::OP_CAST, 0, 0, 0, 0, 1, -1, 0);
    send_word(rbsfh_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_word(rbsfh_pkg::OP_CAST, 0, 3 << 16, 3 << 16, 3 << 16,
              -(1 << 16), -(1 << 16), -(1 << 16));
    // inverted box: minimum above maximum
    send_word(rbsfh_pkg::OP_WRITE, 5, 2 << 16, 2 << 16, 2 << 16,
              -(2 << 16), -(2 << 16), -(2 << 16));
    send_word(OP_UNUSED, 5, '1, '1, '1, '1, '1, '1);
    send_word(rbsfh_pkg::OP_CLEAR, 1023, 0, 0, 0, 0, 0, 0);
    send_word(rbsfh_pkg::OP_CAST, 1023, -(8 << 16), 1 << 15, 0, 1 << 16, 0, 0);
    send_word(rbsfh_pkg::OP_CAST, 0, 0, 0, 0, rbsfh_pkg::Q_MAX, rbsfh_pkg::Q_MAX,
              rbsfh_pkg::Q_MAX);
    send_word(rbsfh_pkg::OP_WRITE, 512, '1, '1, '1, '1, '1, '1);
    send_word(rbsfh_pkg::OP_CAST, 0, '1, '1, '1, '1, '1, '1);
    send_word(rbsfh_pkg::OP_CLEAR, 5, 0, 0, 0, 0, 0, 0);
    wait_drained();

    for (int n = 0; n < 580; n++) begin
      if (n == 300) wait_drained();
      kind = $urandom_range(0, 99);
      wide = ($urandom_range(0, 7) == 0);
      if (kind < 35) begin
        lo = pick_coord(1'b0);
        sz = rbsfh_pkg::coord_t'($urandom_range(0, 12 << 16));
        if (wide)
          send_word(rbsfh_pkg::OP_WRITE, SW'($urandom), pick_coord(1), pick_coord(1),
                    pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1));
        else
          send_word(rbsfh_pkg::OP_WRITE, SW'($urandom_range(0, 31)), lo, pick_coord(0),
                    pick_coord(0), lo + sz, pick_coord(0), pick_coord(0));
      end else if (kind < 45) begin
        send_word(rbsfh_pkg::OP_CLEAR, wide ? SW'($urandom) : SW'($urandom_range(0, 31)),
                  pick_coord(1), pick_coord(1), pick_coord(1),
                  pick_coord(1), pick_coord(1), pick_coord(1));
      end else if (kind < 95) begin
        send_word(rbsfh_pkg::OP_CAST, SW'($urandom), pick_coord(wide), pick_coord(wide),
                  pick_coord(wide), pick_dir(wide), pick_dir(wide), pick_dir(wide));
      end else begin
        send_word(OP_UNUSED, SW'($urandom), pick_coord(1), pick_coord(1), pick_coord(1),
                  pick_coord(1), pick_coord(1), pick_coord(1));
      end
    end
    wait_drained();
    repeat (1200) @(posedge clk_i);
    if (sb.errors == 0)
      $display("PASS ray_box_slab_first_hit_unit");
    else
      $display("FAIL ray_box_slab_first_hit_unit");
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL ray_box_slab_first_hit_unit");
    $finish;
  end

endmodule

/* sim.f */
rtl/rbsfh_pkg.sv
rtl/rbsfh_ram.sv
rtl/rbsfh_recip.sv
rtl/rbsfh_slab.sv
rtl/ray_box_slab_first_hit_unit.sv
dv/tb_ray_box_slab_first_hit_unit.sv
